// File: hdl/icba_pkg.sv
`default_nettype none

package icba_pkg;

  localparam int MAX_CHANNELS  = 16;
  localparam int MAX_DEPTH     = 1024;
  localparam int SAMPLE_BITS   = 12;
  localparam int CH_BITS       = 4;
  localparam int CH_CNT_BITS   = 5;
  localparam int DEPTH_BITS    = 11;
  localparam int ROW_BITS      = 10;
  localparam int SUM_BITS      = 22;
  localparam int AVG_BITS      = 12;
  localparam int DIV_STEPS     = SUM_BITS;
  localparam int DIV_CNT_BITS  = 5;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 11;

  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_DEPTH   = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic final_row;
    logic div_done;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hdl/interleaved_channel_block_average_unit.sv
// Interleaved channel block averager.
// Samples enter on the in_ channel (in_valid, in_stall, in_sample), interleaved
// as channel 0 up to channel_count-1, one row after another, block_depth rows
// per block. A running sum is kept per channel. The final row's sample of each
// channel produces one request on the out_ channel with the channel index, the
// floor average of the block and a last flag on the final channel.
// A sample that does not end a block is added to its channel's sum without
// stalling the input and gives no result. A sample of the final row starts a
// restoring divider that retires one quotient bit per cycle, one for each of
// the 22 sum bits; its result then enters the output register, and only after
// that is the next sample taken. in_stall stays high while the divider runs and
// until the result is loaded. The output register lets the next sample in while
// a result waits; when out_stall holds the result and the divider has finished
// again, the block stalls its input until the output register is free.
// Reset sets channel_count and block_depth to 1 and clears all sums and
// positions. Writing either register through cfg_we, cfg_index and cfg_wdata
// also clears the sums and positions, so a new block starts with the next
// sample.
`default_nettype none

module interleaved_channel_block_average_unit (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire  [icba_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire  [icba_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  [icba_pkg::SAMPLE_BITS-1:0]    in_sample,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [icba_pkg::CH_BITS-1:0]        out_channel_index,
  output logic [icba_pkg::AVG_BITS-1:0]       out_average,
  output logic                                out_last
);

  icba_pkg::ctrl_cmd_t  cmd;
  icba_pkg::dp_status_t status;

  icba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  icba_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_channel_index (out_channel_index),
    .out_average       (out_average),
    .out_last          (out_last),
    .cmd               (cmd),
    .status            (status)
  );

endmodule

`default_nettype wire

// File: hdl/icba_ctrl.sv
`default_nettype none

module icba_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  icba_pkg::dp_status_t status,
  output icba_pkg::ctrl_cmd_t  cmd
);

  icba_pkg::state_t state_r;
  icba_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= icba_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      icba_pkg::ST_IDLE: begin
        if (in_valid && status.final_row) begin
          state_nxt = icba_pkg::ST_DIVIDE;
        end
      end
      icba_pkg::ST_DIVIDE: begin
        if (status.div_done) begin
          state_nxt = icba_pkg::ST_HOLD;
        end
      end
      icba_pkg::ST_HOLD: begin
        if (!status.out_busy) begin
          state_nxt = icba_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    cmd.accept   = 1'b0;
    cmd.div_step = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      icba_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      icba_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      icba_pkg::ST_HOLD: begin
        cmd.load_out = !status.out_busy;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/icba_datapath.sv
`default_nettype none

module icba_datapath (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire  [icba_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire  [icba_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
  input  wire  [icba_pkg::SAMPLE_BITS-1:0]      in_sample,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [icba_pkg::CH_BITS-1:0]          out_channel_index,
  output logic [icba_pkg::AVG_BITS-1:0]         out_average,
  output logic                                  out_last,
  input  icba_pkg::ctrl_cmd_t                   cmd,
  output icba_pkg::dp_status_t                  status
);

  logic [icba_pkg::CH_CNT_BITS-1:0] chan_cnt_r;
  logic [icba_pkg::DEPTH_BITS-1:0]  depth_r;
  logic [icba_pkg::SUM_BITS-1:0]    sums_r [icba_pkg::MAX_CHANNELS];
  logic [icba_pkg::CH_BITS-1:0]     ch_pos_r;
  logic [icba_pkg::ROW_BITS-1:0]    row_pos_r;

  logic [icba_pkg::SUM_BITS-1:0]     quo_r;
  logic [icba_pkg::DEPTH_BITS-1:0]   rem_r;
  logic [icba_pkg::DIV_CNT_BITS-1:0] div_cnt_r;
  logic [icba_pkg::CH_BITS-1:0]      res_ch_r;
  logic                              res_last_r;

  logic                              out_valid_r;
  logic [icba_pkg::CH_BITS-1:0]      out_ch_r;
  logic [icba_pkg::AVG_BITS-1:0]     out_avg_r;
  logic                              out_last_r;

  logic [icba_pkg::CH_CNT_BITS-1:0]  eff_chans;
  logic [icba_pkg::DEPTH_BITS-1:0]   eff_depth;
  logic [icba_pkg::CH_BITS-1:0]      cur_ch;
  logic [icba_pkg::ROW_BITS-1:0]     cur_row;
  logic                              final_row;
  logic                              final_ch;
  logic [icba_pkg::SUM_BITS-1:0]     new_sum;
  logic [icba_pkg::DEPTH_BITS:0]     trial;
  logic                              trial_ge;

  always_comb begin
    eff_chans = chan_cnt_r;
    if (chan_cnt_r == '0) begin
      eff_chans = icba_pkg::CH_CNT_BITS'(1);
    end else if (chan_cnt_r > icba_pkg::CH_CNT_BITS'(icba_pkg::MAX_CHANNELS)) begin
      eff_chans = icba_pkg::CH_CNT_BITS'(icba_pkg::MAX_CHANNELS);
    end
    eff_depth = depth_r;
    if (depth_r == '0) begin
      eff_depth = icba_pkg::DEPTH_BITS'(1);
    end else if (depth_r > icba_pkg::DEPTH_BITS'(icba_pkg::MAX_DEPTH)) begin
      eff_depth = icba_pkg::DEPTH_BITS'(icba_pkg::MAX_DEPTH);
    end
  end

  always_comb begin
    cur_ch = ch_pos_r;
    if ({1'b0, ch_pos_r} >= eff_chans) begin
      cur_ch = '0;
    end
    cur_row = row_pos_r;
    if ({1'b0, row_pos_r} >= eff_depth) begin
      cur_row = '0;
    end
    final_row = ({1'b0, cur_row} == eff_depth - icba_pkg::DEPTH_BITS'(1));
    final_ch  = ({1'b0, cur_ch} == eff_chans - icba_pkg::CH_CNT_BITS'(1));
    new_sum   = sums_r[cur_ch] + icba_pkg::SUM_BITS'(in_sample);
  end

  assign trial    = {rem_r, quo_r[icba_pkg::SUM_BITS-1]};
  assign trial_ge = (trial >= {1'b0, eff_depth});

  assign status.final_row = final_row;
  assign status.div_done  = (div_cnt_r == icba_pkg::DIV_CNT_BITS'(icba_pkg::DIV_STEPS - 1));
  assign status.out_busy  = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= icba_pkg::CH_CNT_BITS'(1);
      depth_r    <= icba_pkg::DEPTH_BITS'(1);
      ch_pos_r   <= '0;
      row_pos_r  <= '0;
      for (int k = 0; k < icba_pkg::MAX_CHANNELS; k++) begin
        sums_r[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == icba_pkg::REG_CHANNEL_COUNT) begin
        chan_cnt_r <= cfg_wdata[icba_pkg::CH_CNT_BITS-1:0];
      end
      if (cfg_index == icba_pkg::REG_CHANNEL_COUNT ||
          cfg_index == icba_pkg::REG_BLOCK_DEPTH) begin
        ch_pos_r  <= '0;
        row_pos_r <= '0;
        for (int k = 0; k < icba_pkg::MAX_CHANNELS; k++) begin
          sums_r[k] <= '0;
        end
      end
      if (cfg_index == icba_pkg::REG_BLOCK_DEPTH) begin
        depth_r <= cfg_wdata;
      end
    end else if (cmd.accept) begin
      sums_r[cur_ch] <= final_row ? '0 : new_sum;
      if (final_ch) begin
        ch_pos_r  <= '0;
        row_pos_r <= final_row ? '0 : cur_row + icba_pkg::ROW_BITS'(1);
      end else begin
        ch_pos_r  <= cur_ch + icba_pkg::CH_BITS'(1);
        row_pos_r <= cur_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      quo_r      <= new_sum;
      rem_r      <= '0;
      div_cnt_r  <= '0;
      res_ch_r   <= cur_ch;
      res_last_r <= final_ch;
    end else if (cmd.div_step) begin
      quo_r     <= {quo_r[icba_pkg::SUM_BITS-2:0], trial_ge};
      rem_r     <= trial_ge ? icba_pkg::DEPTH_BITS'(trial - {1'b0, eff_depth})
                            : trial[icba_pkg::DEPTH_BITS-1:0];
      div_cnt_r <= div_cnt_r + icba_pkg::DIV_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ch_r   <= res_ch_r;
      out_avg_r  <= quo_r[icba_pkg::AVG_BITS-1:0];
      out_last_r <= res_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel_index = out_ch_r;
  assign out_average       = out_avg_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire
